FILE: rtl/smva_pkg.sv
// shared types and constants for the scaled matrix-vector accumulate block
// no dependencies; imported by smva_mac, the top module and the testbench
package smva_pkg;

	localparam int ROWS    = 64;
	localparam int COLS    = 64;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 6;
	localparam int DIM_W   = 7;
	localparam int ELEM_W  = 16;
	localparam int ACC_W   = 32;
	localparam int SCALE_W = 16;
	localparam int FRAC_W  = 8;
	localparam int PROD1_W = SCALE_W + ELEM_W;
	localparam int PROD_W  = PROD1_W + ELEM_W;
	localparam int SHR_W   = PROD_W - FRAC_W;
	localparam int SUM_W   = SHR_W + 1;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 40;
	localparam int IDX_W   = 2;

	typedef enum logic [1:0] {
		OP_LOAD_X = 2'd0,
		OP_LOAD_Y = 2'd1,
		OP_ACCUM  = 2'd2,
		OP_READ_Y = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	localparam logic [IDX_W-1:0] REG_ROWS  = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLS  = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE = 2'd2;

	typedef struct packed {
		op_t                     op;
		logic                    err;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [ACC_W-1:0] value;
	} item_t;

endpackage

FILE: rtl/smva_ram.sv
// generic synchronous ram: one write port, one read port, registered read data
// no dependencies
module smva_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/smva_mac.sv
// scaled multiply, truncating shift and saturating add, result and status for one item
// depends on smva_pkg
module smva_mac (
	input  logic                              clk,
	input  logic                              en1,
	input  logic                              en2,
	input  logic signed [smva_pkg::SCALE_W-1:0] scale,
	input  smva_pkg::item_t                   item_s1,
	input  logic signed [smva_pkg::ELEM_W-1:0]  x_rd,
	input  logic signed [smva_pkg::ACC_W-1:0]   y_rd,
	output smva_pkg::item_t                   item_s3,
	output smva_pkg::status_t                 status,
	output logic signed [smva_pkg::ACC_W-1:0]   y_value
);
	import smva_pkg::*;

	logic signed [ELEM_W-1:0]  a_s1;
	logic signed [PROD1_W-1:0] prod1_d;
	logic signed [PROD1_W-1:0] prod1_s2;
	logic signed [ELEM_W-1:0]  x_s2;
	logic signed [ACC_W-1:0]   y_s2;
	item_t                     item_s2;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [ACC_W-1:0]   y_s3;
	logic [SHR_W-1:0]          shr;
	logic [SUM_W-1:0]          sum;
	logic                      ovf;
	logic signed [ACC_W-1:0]   acc_res;

	assign a_s1    = item_s1.value[ELEM_W-1:0];
	assign prod1_d = scale * a_s1;
	assign prod_d  = prod1_s2 * x_s2;

	always_ff @(posedge clk) begin
		if (en1) begin
			prod1_s2 <= prod1_d;
			x_s2     <= x_rd;
			y_s2     <= y_rd;
			item_s2  <= item_s1;
		end
		if (en2) begin
			prod_s3 <= prod_d;
			y_s3    <= y_s2;
			item_s3 <= item_s2;
		end
	end

	// arithmetic shift drops the fraction, rounding toward minus infinity
	assign shr = prod_s3[PROD_W-1:FRAC_W];
	assign sum = {{(SUM_W-ACC_W){y_s3[ACC_W-1]}}, y_s3} + {shr[SHR_W-1], shr};
	// overflow when the bits above the accumulator sign are not all copies of it
	assign ovf = !((&sum[SUM_W-1:ACC_W-1]) || !(|sum[SUM_W-1:ACC_W-1]));

	always_comb begin
		if (!ovf) begin
			acc_res = sum[ACC_W-1:0];
		end else if (sum[SUM_W-1]) begin
			acc_res = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			acc_res = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	always_comb begin
		status  = ST_OK;
		y_value = '0;
		if (item_s3.err) begin
			status = ST_RANGE;
		end else begin
			case (item_s3.op)
				OP_LOAD_X: y_value = '0;
				OP_LOAD_Y: y_value = item_s3.value;
				OP_ACCUM: begin
					y_value = acc_res;
					if (ovf) status = ST_SAT;
				end
				OP_READ_Y: y_value = y_s3;
				default:   y_value = '0;
			endcase
		end
	end

endmodule

FILE: rtl/scaled_matrix_vector_accumulate.sv
// y += s*A*x over a 64-entry x vector (16-bit) and a 64-entry accumulator y
// (32-bit), each held in a synchronous ram; one item is in flight at a time and
// passes through a ram read, the scale*A multiply, the product with x[col], and
// then add, saturate and write back. The output register lets the next item be
// accepted while a result waits. Entries of x and y read before being loaded
// return undefined data.
// depends on smva_pkg, smva_ram, smva_mac
module scaled_matrix_vector_accumulate (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [smva_pkg::IDX_W-1:0]     cfg_index,
	input  logic [smva_pkg::SCALE_W-1:0]   cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// operation[1:0], row[7:2], col[13:8], value[45:14], zero [47:46]
	input  logic [smva_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// status[1:0], y_value[33:2], zero [39:34]
	output logic [smva_pkg::OUT_W-1:0]     m_axis_tdata
);
	import smva_pkg::*;

	logic [DIM_W-1:0]          rows_q;
	logic [DIM_W-1:0]          cols_q;
	logic signed [SCALE_W-1:0] scale_q;

	item_t                     in_item;
	logic                      in_err;
	item_t                     item_s1;
	item_t                     item_s3;
	logic                      v1_s1, v2_s2, v3_s3;
	logic                      s_fire, fire3;
	logic [DIM_W-1:0]          row_lim, col_lim;
	logic                      row_ok, col_ok;

	logic signed [ELEM_W-1:0]  x_rd;
	logic signed [ACC_W-1:0]   y_rd;
	logic                      x_we, y_we;
	logic [ROW_W-1:0]          y_waddr;
	logic signed [ACC_W-1:0]   y_wdata;

	status_t                   res_status;
	logic signed [ACC_W-1:0]   res_y;
	logic                      out_v_q;
	logic [1:0]                out_status_q;
	logic signed [ACC_W-1:0]   out_y_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_W'(ROWS);
			cols_q  <= DIM_W'(COLS);
			scale_q <= SCALE_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS:  rows_q  <= cfg_wdata[DIM_W-1:0];
				REG_COLS:  cols_q  <= cfg_wdata[DIM_W-1:0];
				REG_SCALE: scale_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	assign row_lim = (rows_q > DIM_W'(ROWS)) ? DIM_W'(ROWS) : rows_q;
	assign col_lim = (cols_q > DIM_W'(COLS)) ? DIM_W'(COLS) : cols_q;

	assign in_item.op    = op_t'(s_axis_tdata[1:0]);
	assign in_item.row   = s_axis_tdata[7:2];
	assign in_item.col   = s_axis_tdata[13:8];
	assign in_item.value = s_axis_tdata[45:14];
	assign in_item.err   = in_err;

	assign row_ok = {1'b0, in_item.row} < row_lim;
	assign col_ok = {1'b0, in_item.col} < col_lim;

	// only the indices the operation uses are checked
	always_comb begin
		case (in_item.op)
			OP_LOAD_X: in_err = !col_ok;
			OP_ACCUM:  in_err = !(row_ok && col_ok);
			default:   in_err = !row_ok;
		endcase
	end

	assign s_axis_tready = !(v1_s1 || v2_s2 || v3_s3);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign fire3         = v3_s3 && (!out_v_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			v1_s1 <= s_fire;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2 || (v3_s3 && !fire3);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1 <= in_item;
		end
	end

	// loads write at the first stage, accumulates write back when the result leaves
	assign x_we    = v1_s1 && (item_s1.op == OP_LOAD_X) && !item_s1.err;
	assign y_we    = (v1_s1 && (item_s1.op == OP_LOAD_Y) && !item_s1.err)
		|| (fire3 && (item_s3.op == OP_ACCUM) && !item_s3.err);
	assign y_waddr = v1_s1 ? item_s1.row : item_s3.row;
	assign y_wdata = v1_s1 ? item_s1.value : res_y;

	smva_ram #(.WIDTH(ELEM_W), .DEPTH(COLS)) u_x_ram (
		.clk   (clk),
		.we    (x_we),
		.waddr (item_s1.col),
		.wdata (item_s1.value[ELEM_W-1:0]),
		.re    (s_fire),
		.raddr (in_item.col),
		.rdata (x_rd)
	);

	smva_ram #(.WIDTH(ACC_W), .DEPTH(ROWS)) u_y_ram (
		.clk   (clk),
		.we    (y_we),
		.waddr (y_waddr),
		.wdata (y_wdata),
		.re    (s_fire),
		.raddr (in_item.row),
		.rdata (y_rd)
	);

	smva_mac u_mac (
		.clk     (clk),
		.en1     (v1_s1),
		.en2     (v2_s2),
		.scale   (scale_q),
		.item_s1 (item_s1),
		.x_rd    (x_rd),
		.y_rd    (y_rd),
		.item_s3 (item_s3),
		.status  (res_status),
		.y_value (res_y)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire3) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire3) begin
			out_status_q <= res_status;
			out_y_q      <= res_y;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {6'b0, out_y_q, out_status_q};

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v1_s1, v2_s2, v3_s3}))
		else $error("more than one item in flight");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> v1_s1 && !s_axis_tready)
		else $error("accepted transfer did not enter the first stage");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(fire3 && res_status == ST_SAT) |->
		(res_y == {1'b1, {(ACC_W-1){1'b0}}} || res_y == {1'b0, {(ACC_W-1){1'b1}}}))
		else $error("saturation status without a clamped accumulator");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire3 && item_s3.err) |-> !y_we && res_y == '0)
		else $error("out of range item changed state or gave data");
`endif

endmodule

FILE: test/scaled_matrix_vector_accumulate_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for scaled_matrix_vector_accumulate (y += s*A*x)
// depends on smva_pkg and the block's rtl; keeps its own copy of x, y and the registers
module scaled_matrix_vector_accumulate_tb;
	import smva_pkg::*;

	localparam int  HOLD_CYCLES = 300;
	localparam int  CYCLE_LIMIT = 600000;
	localparam int  TAIL_CYCLES = 12;
	localparam longint ACC_MAX  = 64'sd2147483647;
	localparam longint ACC_MIN  = -64'sd2147483648;

	typedef struct {
		status_t     status;
		logic [31:0] y_value;
	} y_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_index;
	logic [SCALE_W-1:0]   cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;

	// shadow state of the block
	logic signed [15:0]   x_vec [COLS];
	logic signed [31:0]   y_acc [ROWS];
	bit                   x_loaded [COLS];
	bit                   y_loaded [ROWS];
	logic [DIM_W-1:0]     rows_reg;
	logic [DIM_W-1:0]     cols_reg;
	logic signed [15:0]   scale_reg;

	y_result_t            expected_y [$];
	int                   error_count;
	int                   items_sent;
	int                   results_seen;
	int                   range_seen;
	int                   sat_seen;
	int                   cycle_count;
	bit                   gaps_on;
	bit                   stalls_on;
	bit                   hold_req;

	scaled_matrix_vector_accumulate u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("scaled_matrix_vector_accumulate regression: fail");
			$finish;
		end
	end

	function automatic int row_limit();
		return (rows_reg > ROWS) ? ROWS : int'(rows_reg);
	endfunction

	function automatic int col_limit();
		return (cols_reg > COLS) ? COLS : int'(cols_reg);
	endfunction

	// applies one item to the shadow state and gives the result it should produce
	function automatic y_result_t accumulate_item(op_t op, logic [5:0] row, logic [5:0] col,
			logic [31:0] value);
		y_result_t r;
		bit        row_in;
		bit        col_in;
		longint    prod;
		longint    sum;
		r.status  = ST_OK;
		r.y_value = '0;
		row_in    = int'(row) < row_limit();
		col_in    = int'(col) < col_limit();
		case (op)
			OP_LOAD_X: begin
				if (col_in) begin
					x_vec[col]    = value[15:0];
					x_loaded[col] = 1'b1;
				end else begin
					r.status = ST_RANGE;
				end
			end
			OP_LOAD_Y: begin
				if (row_in) begin
					y_acc[row]    = value;
					y_loaded[row] = 1'b1;
					r.y_value     = value;
				end else begin
					r.status = ST_RANGE;
				end
			end
			OP_ACCUM: begin
				if (row_in && col_in) begin
					prod = longint'(scale_reg) * longint'($signed(value[15:0]))
						* longint'(x_vec[col]);
					// arithmetic shift, so negative products round down
					sum = longint'(y_acc[row]) + (prod >>> FRAC_W);
					if (sum > ACC_MAX) begin
						sum      = ACC_MAX;
						r.status = ST_SAT;
					end else if (sum < ACC_MIN) begin
						sum      = ACC_MIN;
						r.status = ST_SAT;
					end
					y_acc[row] = sum[31:0];
					r.y_value  = sum[31:0];
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: begin
				if (row_in)
					r.y_value = y_acc[row];
				else
					r.status = ST_RANGE;
			end
		endcase
		return r;
	endfunction

	task automatic send_item(op_t op, logic [5:0] row, logic [5:0] col, logic [31:0] value);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, value, col, row, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_y.push_back(accumulate_item(op, row, col, value));
		items_sent++;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// drains the block so that a register write sees it idle
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_y.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] index, logic [SCALE_W-1:0] data);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (index)
			REG_ROWS:  rows_reg  = data[DIM_W-1:0];
			REG_COLS:  cols_reg  = data[DIM_W-1:0];
			REG_SCALE: scale_reg = data;
			default: ;
		endcase
	endtask

	// dimension writes carry random junk above bit 6, which the block must ignore
	task automatic set_dims(int rows, int cols, logic [15:0] scale);
		write_reg(REG_ROWS, {9'($urandom), 7'(rows)});
		write_reg(REG_COLS, {9'($urandom), 7'(cols)});
		write_reg(REG_SCALE, scale);
	endtask

	function automatic logic [31:0] rand_elem();
		logic [15:0] low;
		case ($urandom_range(0, 7))
			0:       low = 16'h7FFF;
			1:       low = 16'h8000;
			2:       low = 16'($urandom_range(0, 3)) - 16'd1;
			default: low = 16'($urandom);
		endcase
		return {16'($urandom), low};
	endfunction

	function automatic logic [31:0] rand_acc();
		case ($urandom_range(0, 7))
			0:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 4000));
			1:       return 32'h8000_0000 + 32'($urandom_range(0, 4000));
			2:       return 32'($urandom_range(0, 200)) - 32'd100;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [5:0] pick_index(int lim);
		if (lim == 0 || $urandom_range(0, 9) == 0)
			return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, lim - 1));
	endfunction

	// mostly accumulate streams over loaded entries, with some out-of-range noise
	task automatic random_items(int n);
		op_t         op;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [31:0] value;
		int          pick;
		bit          row_in;
		bit          col_in;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 3)
				op = OP_LOAD_X;
			else if (pick < 6)
				op = OP_LOAD_Y;
			else if (pick < 17)
				op = OP_ACCUM;
			else
				op = OP_READ_Y;
			row    = pick_index(row_limit());
			col    = pick_index(col_limit());
			row_in = int'(row) < row_limit();
			col_in = int'(col) < col_limit();
			// never let the block read an entry that was not loaded
			if (op == OP_ACCUM && row_in && col_in && !x_loaded[col])
				send_item(OP_LOAD_X, row, col, rand_elem());
			if ((op == OP_ACCUM && row_in && col_in || op == OP_READ_Y && row_in)
					&& !y_loaded[row])
				send_item(OP_LOAD_Y, row, col, rand_acc());
			value = (op == OP_LOAD_Y) ? rand_acc() : rand_elem();
			if (op == OP_READ_Y && $urandom_range(0, 1) == 0)
				value = $urandom;
			send_item(op, row, col, value);
		end
	endtask

	always @(posedge clk) begin : result_check
		y_result_t   want;
		logic [1:0]  got_status;
		logic [31:0] got_y;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_status = m_axis_tdata[1:0];
			got_y      = m_axis_tdata[33:2];
			results_seen++;
			if (got_status == ST_RANGE)
				range_seen++;
			if (got_status == ST_SAT)
				sat_seen++;
			if (expected_y.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: status %0d y %h", got_status, got_y);
			end else begin
				want = expected_y.pop_front();
				if (got_status != want.status || got_y != want.y_value || m_axis_tdata[39:34] != 0)
						begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch at result %0d: status %0d y %h, wanted status %0d y %h",
							results_seen, got_status, got_y, want.status, want.y_value);
				end
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_req = 1'b0;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1)
					@(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic test_directed();
		send_item(OP_LOAD_X, 6'd5, 6'd0, 32'hABCD_0001);
		send_item(OP_LOAD_X, 6'd0, 6'd63, 32'h1234_7FFF);
		send_item(OP_LOAD_X, 6'd0, 6'd1, 32'hFFFF_8000);
		send_item(OP_LOAD_Y, 6'd0, 6'd9, 32'h0000_0000);
		send_item(OP_LOAD_Y, 6'd63, 6'd0, 32'h7FFF_FFFF);
		send_item(OP_LOAD_Y, 6'd1, 6'd0, 32'h8000_0000);
		send_item(OP_ACCUM, 6'd0, 6'd0, 32'h0000_FFFF);
		// positive and negative saturation
		send_item(OP_ACCUM, 6'd63, 6'd63, 32'hFFFF_7FFF);
		send_item(OP_ACCUM, 6'd1, 6'd1, 32'h0000_7FFF);
		send_item(OP_READ_Y, 6'd0, 6'd63, 32'hFFFF_FFFF);
		send_item(OP_READ_Y, 6'd63, 6'd0, 32'h0);
		send_item(OP_READ_Y, 6'd1, 6'd0, 32'h0);
		// one row and one column: index 1 is out of range on every operation
		set_dims(1, 1, 16'sd256);
		send_item(OP_LOAD_X, 6'd0, 6'd1, 32'h0000_1111);
		send_item(OP_LOAD_Y, 6'd1, 6'd0, 32'h2222_2222);
		send_item(OP_ACCUM, 6'd1, 6'd0, 32'h0000_0001);
		send_item(OP_ACCUM, 6'd0, 6'd1, 32'h0000_0001);
		send_item(OP_READ_Y, 6'd1, 6'd0, 32'h0);
		send_item(OP_ACCUM, 6'd0, 6'd0, 32'h0000_0003);
		// tiny scale: product -1/256 must round down to -1
		write_reg(REG_SCALE, 16'sd1);
		send_item(OP_ACCUM, 6'd0, 6'd0, 32'h0000_FFFF);
		// zero dimensions reject everything
		set_dims(0, 0, 16'h8000);
		send_item(OP_READ_Y, 6'd0, 6'd0, 32'h0);
		send_item(OP_LOAD_X, 6'd0, 6'd0, 32'h0000_7777);
		send_item(OP_ACCUM, 6'd0, 6'd0, 32'h0000_0001);
		// dimensions above the array size clamp to the full size
		set_dims(127, 127, 16'sd256);
		send_item(OP_READ_Y, 6'd63, 6'd0, 32'h0);
		send_item(OP_ACCUM, 6'd63, 6'd63, 32'h0);
	endtask

	task automatic run_phase(int rows, int cols, logic [15:0] scale, int n);
		set_dims(rows, cols, scale);
		random_items(n);
	endtask

	task automatic test_random_sweep();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		run_phase(64, 64, 16'sd256, 180);
		run_phase(127, 127, 16'($urandom), 170);
		run_phase(1, 1, 16'sh7FFF, 150);
		run_phase(5, 3, 16'sh8000, 170);
		gaps_on = 1'b0;
		run_phase(33, 64, 16'($urandom), 170);
		gaps_on = 1'b1;
		run_phase(64, 17, 16'hFFFF, 170);
		run_phase(0, 0, 16'($urandom), 40);
		run_phase(64, 64, 16'h0000, 120);
		run_phase(64, 64, 16'($urandom), 170);
	endtask

	// receiver holds off while items keep coming, so the block must stall its input
	task automatic test_backpressure();
		set_dims(64, 64, 16'($urandom));
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		random_items(40);
		wait_idle();
	endtask

	task automatic test_streaming();
		set_dims(64, 64, 16'sd256);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		random_items(200);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		rows_reg      = 7'd64;
		cols_reg      = 7'd64;
		scale_reg     = 16'sd256;
		error_count   = 0;
		items_sent    = 0;
		results_seen  = 0;
		range_seen    = 0;
		sat_seen      = 0;
		cycle_count   = 0;
		gaps_on       = 1'b0;
		stalls_on     = 1'b0;
		hold_req      = 1'b0;
		for (int i = 0; i < COLS; i++)
			x_loaded[i] = 1'b0;
		for (int i = 0; i < ROWS; i++)
			y_loaded[i] = 1'b0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_sweep();
		test_backpressure();
		test_streaming();
		wait_idle();

		$display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
			results_seen, error_count);
		$display("covered %0d range rejections and %0d saturated sums over many sizes and scales",
			range_seen, sat_seen);
		if (error_count == 0 && expected_y.size() == 0) begin
			$display("scaled_matrix_vector_accumulate regression: pass");
		end else begin
			$display("scaled_matrix_vector_accumulate regression: fail");
		end
		$finish;
	end

endmodule
